// ===== design/sbc_pkg.sv =====
`default_nettype none
package sbc_pkg;

	localparam int COORD_W  = 32;
	localparam int FRAC_W   = 16;
	localparam int Q_W      = FRAC_W + 1;
	localparam int T_W      = FRAC_W + 3;
	localparam int DIV_LAT  = Q_W + 1;
	localparam int NUM_AX   = 3;
	localparam int NUM_DIV  = 2 * NUM_AX;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W   = COORD_W + Q_W;

	localparam logic signed [T_W-1:0] T_ZERO    = '0;
	localparam logic signed [T_W-1:0] T_ONE     = T_W'(1) << FRAC_W;
	localparam logic signed [T_W-1:0] T_NEG_ONE = -T_ONE;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [COORD_W-1:0] mag_t;
	typedef logic signed [T_W-1:0] tpar_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [NUM_AX-1:0][COORD_W-1:0] p0;
		logic [NUM_AX-1:0][COORD_W-1:0] p1;
		logic [NUM_AX-1:0][COORD_W-1:0] dmag;
		logic [NUM_AX-1:0] dneg;
		logic [NUM_AX-1:0] zero;
		logic [NUM_AX-1:0] zpass;
	} side_t;

	typedef struct packed {
		side_t side;
		logic [NUM_DIV-1:0][T_W-1:0] u;
		logic [T_W-1:0] t0;
		logic [T_W-1:0] t1;
		logic hit;
	} axis_t;

	function automatic mag_t mag_of(logic signed [COORD_W:0] v);
		logic signed [COORD_W:0] n;
		n = v[COORD_W] ? -v : v;
		return n[COORD_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/sbc_if.sv =====
`default_nettype none
interface sbc_seg_if;
	logic valid;
	logic ready;
	logic signed [sbc_pkg::COORD_W-1:0] begin_x;
	logic signed [sbc_pkg::COORD_W-1:0] begin_y;
	logic signed [sbc_pkg::COORD_W-1:0] begin_z;
	logic signed [sbc_pkg::COORD_W-1:0] end_x;
	logic signed [sbc_pkg::COORD_W-1:0] end_y;
	logic signed [sbc_pkg::COORD_W-1:0] end_z;
	modport source (output valid, begin_x, begin_y, begin_z, end_x, end_y, end_z,
		input ready);
	modport sink (input valid, begin_x, begin_y, begin_z, end_x, end_y, end_z,
		output ready);
endinterface

interface sbc_clip_if;
	logic valid;
	logic ready;
	logic hit;
	logic signed [sbc_pkg::COORD_W-1:0] clip_begin_x;
	logic signed [sbc_pkg::COORD_W-1:0] clip_begin_y;
	logic signed [sbc_pkg::COORD_W-1:0] clip_begin_z;
	logic signed [sbc_pkg::COORD_W-1:0] clip_end_x;
	logic signed [sbc_pkg::COORD_W-1:0] clip_end_y;
	logic signed [sbc_pkg::COORD_W-1:0] clip_end_z;
	modport source (output valid, hit, clip_begin_x, clip_begin_y, clip_begin_z,
		clip_end_x, clip_end_y, clip_end_z, input ready);
	modport sink (input valid, hit, clip_begin_x, clip_begin_y, clip_begin_z,
		clip_end_x, clip_end_y, clip_end_z, output ready);
endinterface

interface sbc_cfg_if;
	logic valid;
	logic ready;
	logic [sbc_pkg::CFG_IDX_W-1:0] index;
	logic [sbc_pkg::COORD_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/sbc_div.sv =====
`default_nettype none
module sbc_div (
	input  wire logic clk,
	input  wire logic en,
	input  wire sbc_pkg::mag_t nm,
	input  wire sbc_pkg::mag_t dm,
	input  wire logic neg,
	output sbc_pkg::tpar_t u
);

	localparam int CW = sbc_pkg::COORD_W;
	localparam int QW = sbc_pkg::Q_W;
	localparam int TW = sbc_pkg::T_W;

	logic [CW:0] rem_s [QW];
	logic [QW-1:0] quo_s [QW];
	sbc_pkg::mag_t dm_s [QW];
	logic neg_s [QW];
	logic sat_s [QW];
	sbc_pkg::tpar_t u_s;

	logic sat0, bit0;
	logic [CW:0] rem0;

	always_comb begin
		sat0 = {1'b0, nm} >= {dm, 1'b0};
		bit0 = nm >= dm;
		rem0 = bit0 ? ({1'b0, nm} - {1'b0, dm}) : {1'b0, nm};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rem0;
			quo_s[0] <= {{(QW-1){1'b0}}, bit0};
			dm_s[0]  <= dm;
			neg_s[0] <= neg;
			sat_s[0] <= sat0;
		end
	end

	for (genvar k = 1; k < QW; k++) begin : g_step
		logic [CW:0] r2, rn;
		logic bk;
		always_comb begin
			r2 = {rem_s[k-1][CW-1:0], 1'b0};
			bk = r2 >= {1'b0, dm_s[k-1]};
			rn = bk ? (r2 - {1'b0, dm_s[k-1]}) : r2;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rn;
				quo_s[k] <= {quo_s[k-1][QW-2:0], bk};
				dm_s[k]  <= dm_s[k-1];
				neg_s[k] <= neg_s[k-1];
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	logic [QW:0] mag_f;
	sbc_pkg::tpar_t v_f;

	always_comb begin
		mag_f = sat_s[QW-1] ? ((QW+1)'(1) << QW) : {1'b0, quo_s[QW-1]};
		v_f = neg_s[QW-1] ? -$signed({1'b0, mag_f}) : $signed({1'b0, mag_f});
		if (v_f < sbc_pkg::T_NEG_ONE) begin
			v_f = sbc_pkg::T_NEG_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s <= TW'(v_f);
		end
	end

	assign u = u_s;

endmodule
`default_nettype wire

// ===== design/segment_box_clip_unit.sv =====
`default_nettype none
// Channel   Role    Handshake      Payload
// seg       sink    valid/ready    begin_x/y/z, end_x/y/z
// clip      source  valid/ready    hit, clip_begin_x/y/z, clip_end_x/y/z
// cfg       sink    valid/ready    index, data (ready is always high)
//
// One segment enters per clock while the output is not stalled.
// Most of the pipeline is the restoring dividers, one quotient bit per stage.
// Reset clears the box registers to zero and empties the pipeline.
// A stalled output freezes every stage, so seg.ready falls with it.
module segment_box_clip_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	sbc_seg_if.sink seg,
	sbc_clip_if.source clip,
	sbc_cfg_if.sink cfg
);

	localparam int CW = sbc_pkg::COORD_W;
	localparam int FW = sbc_pkg::FRAC_W;
	localparam int QW = sbc_pkg::Q_W;
	localparam int NA = sbc_pkg::NUM_AX;
	localparam int ND = sbc_pkg::NUM_DIV;
	localparam int DL = sbc_pkg::DIV_LAT;
	localparam int PW = sbc_pkg::PROD_W;

	sbc_pkg::coord_t box_min_q [NA];
	sbc_pkg::coord_t box_max_q [NA];

	logic adv;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NA; i++) begin
				box_min_q[i] <= '0;
				box_max_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			unique case (sbc_pkg::reg_idx_t'(cfg.index))
				sbc_pkg::REG_MIN_X: box_min_q[0] <= cfg.data;
				sbc_pkg::REG_MIN_Y: box_min_q[1] <= cfg.data;
				sbc_pkg::REG_MIN_Z: box_min_q[2] <= cfg.data;
				sbc_pkg::REG_MAX_X: box_max_q[0] <= cfg.data;
				sbc_pkg::REG_MAX_Y: box_max_q[1] <= cfg.data;
				sbc_pkg::REG_MAX_Z: box_max_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	assign adv = !clip.valid || clip.ready;
	assign seg.ready = adv;

	// Stage 1: direction, plane numerators and the zero-direction test.
	sbc_pkg::coord_t pa [NA];
	sbc_pkg::coord_t pb [NA];
	sbc_pkg::side_t side_c, side_s1;
	sbc_pkg::mag_t nm_c [ND];
	sbc_pkg::mag_t dm_c [ND];
	logic [ND-1:0] neg_c;
	sbc_pkg::mag_t nm_s1 [ND];
	sbc_pkg::mag_t dm_s1 [ND];
	logic [ND-1:0] neg_s1;
	logic valid_s1;

	assign pa[0] = seg.begin_x;
	assign pa[1] = seg.begin_y;
	assign pa[2] = seg.begin_z;
	assign pb[0] = seg.end_x;
	assign pb[1] = seg.end_y;
	assign pb[2] = seg.end_z;

	for (genvar g = 0; g < NA; g++) begin : g_prep
		logic signed [CW:0] d, n0, n1;
		always_comb begin
			d  = $signed({pb[g][CW-1], pb[g]}) - $signed({pa[g][CW-1], pa[g]});
			n0 = $signed({box_min_q[g][CW-1], box_min_q[g]})
				- $signed({pa[g][CW-1], pa[g]});
			n1 = $signed({box_max_q[g][CW-1], box_max_q[g]})
				- $signed({pa[g][CW-1], pa[g]});
		end
		assign side_c.p0[g]    = pa[g];
		assign side_c.p1[g]    = pb[g];
		assign side_c.dmag[g]  = sbc_pkg::mag_of(d);
		assign side_c.dneg[g]  = d[CW];
		assign side_c.zero[g]  = (d == '0);
		assign side_c.zpass[g] = (box_min_q[g] <= pa[g]) && (pa[g] <= box_max_q[g]);
		assign nm_c[2*g]   = sbc_pkg::mag_of(n0);
		assign nm_c[2*g+1] = sbc_pkg::mag_of(n1);
		assign dm_c[2*g]   = sbc_pkg::mag_of(d);
		assign dm_c[2*g+1] = sbc_pkg::mag_of(d);
		assign neg_c[2*g]   = n0[CW] ^ d[CW];
		assign neg_c[2*g+1] = n1[CW] ^ d[CW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= seg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_c;
			nm_s1   <= nm_c;
			dm_s1   <= dm_c;
			neg_s1  <= neg_c;
		end
	end

	// Slab dividers, with the item's other data delayed alongside.
	sbc_pkg::tpar_t u_div [ND];

	for (genvar k = 0; k < ND; k++) begin : g_div
		sbc_div u_div_i (
			.clk (clk),
			.en  (adv),
			.nm  (nm_s1[k]),
			.dm  (dm_s1[k]),
			.neg (neg_s1[k]),
			.u   (u_div[k])
		);
	end

	sbc_pkg::side_t side_dl [DL];
	logic [DL-1:0] valid_dl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_dl <= '0;
		end else if (adv) begin
			valid_dl <= {valid_dl[DL-2:0], valid_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_dl[0] <= side_s1;
			for (int i = 1; i < DL; i++) begin
				side_dl[i] <= side_dl[i-1];
			end
		end
	end

	// Interval narrowing, one stage per axis.
	sbc_pkg::axis_t ax_init;
	sbc_pkg::axis_t ax_s [NA];
	logic [NA-1:0] valid_ax;

	always_comb begin
		ax_init.side = side_dl[DL-1];
		for (int k = 0; k < ND; k++) begin
			ax_init.u[k] = u_div[k];
		end
		ax_init.t0  = sbc_pkg::T_ZERO;
		ax_init.t1  = sbc_pkg::T_ONE;
		ax_init.hit = 1'b1;
	end

	for (genvar g = 0; g < NA; g++) begin : g_ax
		sbc_pkg::axis_t src, nxt;
		sbc_pkg::tpar_t u0, u1, lo, hi, t0o, t1o, t0n, t1n;
		logic vin;
		if (g == 0) begin : g_first
			assign src = ax_init;
			assign vin = valid_dl[DL-1];
		end else begin : g_next
			assign src = ax_s[g-1];
			assign vin = valid_ax[g-1];
		end
		always_comb begin
			nxt = src;
			u0  = $signed(src.u[2*g]);
			u1  = $signed(src.u[2*g+1]);
			t0o = $signed(src.t0);
			t1o = $signed(src.t1);
			lo  = (u0 > u1) ? u1 : u0;
			hi  = (u0 > u1) ? u0 : u1;
			t0n = (lo > t0o) ? lo : t0o;
			t1n = (hi < t1o) ? hi : t1o;
			if (src.hit) begin
				if (src.side.zero[g]) begin
					nxt.hit = src.side.zpass[g];
				end else if (hi < t0o || lo > t1o) begin
					nxt.hit = 1'b0;
				end else begin
					nxt.t0  = t0n;
					nxt.t1  = t1n;
					nxt.hit = t1n >= t0n;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_ax[g] <= 1'b0;
			end else if (adv) begin
				valid_ax[g] <= vin;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ax_s[g] <= nxt;
			end
		end
	end

	// Endpoint scaling: multiply, round, then offset and select.
	logic [PW-1:0] prod_b_m1 [NA];
	logic [PW-1:0] prod_e_m1 [NA];
	sbc_pkg::side_t side_m1, side_m2;
	logic hit_m1, hit_m2, valid_m1, valid_m2, valid_m3;
	logic signed [CW+1:0] sc_b_m2 [NA];
	logic signed [CW+1:0] sc_e_m2 [NA];
	logic hit_m3;
	sbc_pkg::coord_t cb_m3 [NA];
	sbc_pkg::coord_t ce_m3 [NA];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_m1 <= 1'b0;
			valid_m2 <= 1'b0;
			valid_m3 <= 1'b0;
		end else if (adv) begin
			valid_m1 <= valid_ax[NA-1];
			valid_m2 <= valid_m1;
			valid_m3 <= valid_m2;
		end
	end

	for (genvar g = 0; g < NA; g++) begin : g_scale
		logic [PW-1:0] rb, re;
		logic [CW:0] mb, me;
		logic signed [CW+1:0] sum_b, sum_e;
		always_comb begin
			rb = prod_b_m1[g] + (PW'(1) << (FW - 1));
			re = prod_e_m1[g] + (PW'(1) << (FW - 1));
			mb = rb[FW +: CW + 1];
			me = re[FW +: CW + 1];
			sum_b = $signed({side_m2.p0[g][CW-1], side_m2.p0[g][CW-1], side_m2.p0[g]})
				+ sc_b_m2[g];
			sum_e = $signed({side_m2.p0[g][CW-1], side_m2.p0[g][CW-1], side_m2.p0[g]})
				+ sc_e_m2[g];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				prod_b_m1[g] <= ax_s[NA-1].side.dmag[g] * ax_s[NA-1].t0[QW-1:0];
				prod_e_m1[g] <= ax_s[NA-1].side.dmag[g] * ax_s[NA-1].t1[QW-1:0];
				sc_b_m2[g] <= side_m1.dneg[g] ? -$signed({1'b0, mb}) : $signed({1'b0, mb});
				sc_e_m2[g] <= side_m1.dneg[g] ? -$signed({1'b0, me}) : $signed({1'b0, me});
				cb_m3[g] <= hit_m2 ? sum_b[CW-1:0] : side_m2.p0[g];
				ce_m3[g] <= hit_m2 ? sum_e[CW-1:0] : side_m2.p1[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_m1 <= ax_s[NA-1].side;
			hit_m1  <= ax_s[NA-1].hit;
			side_m2 <= side_m1;
			hit_m2  <= hit_m1;
			hit_m3  <= hit_m2;
		end
	end

	assign clip.valid        = valid_m3;
	assign clip.hit          = hit_m3;
	assign clip.clip_begin_x = cb_m3[0];
	assign clip.clip_begin_y = cb_m3[1];
	assign clip.clip_begin_z = cb_m3[2];
	assign clip.clip_end_x   = ce_m3[0];
	assign clip.clip_end_y   = ce_m3[1];
	assign clip.clip_end_z   = ce_m3[2];

	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_ax[NA-1] |-> ($signed(ax_s[NA-1].t0) >= sbc_pkg::T_ZERO
			&& $signed(ax_s[NA-1].t1) <= sbc_pkg::T_ONE))
		else $error("clip interval left [0, 1]");

	a_hit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_ax[NA-1] && ax_s[NA-1].hit)
			|-> $signed(ax_s[NA-1].t0) <= $signed(ax_s[NA-1].t1))
		else $error("hit with empty interval");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_dl[DL-1] |-> (u_div[0] >= sbc_pkg::T_NEG_ONE
			&& u_div[0] <= (sbc_pkg::T_ONE <<< 1)))
		else $error("slab parameter out of range");

	a_miss_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_m2 && !hit_m2) |=> (cb_m3[0] == $past(side_m2.p0[0])
			&& ce_m3[0] == $past(side_m2.p1[0])))
		else $error("miss did not pass the input points");

endmodule
`default_nettype wire
